// ===== design/pwt_pkg.sv =====
`timescale 1ns / 1ps

package pwt_pkg;

  localparam int PWT_TABLE_FRAMES = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = 9;
  localparam int PAGE_SHIFT = 12;

  localparam int VA_W = 57;
  localparam int PA_W = 64;
  localparam int FLAGS_W = 12;
  localparam int ENTRY_W = 64;
  localparam int TBA_W = 52;
  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 64;

  localparam logic [ENTRY_W-1:0] LINK_BITS = 64'h7;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_MAP       = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NOFRAME  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  localparam logic REG_PAGING_MODE = 1'b0;
  localparam logic REG_TABLE_BASE  = 1'b1;

endpackage

// ===== design/pwt_table_mem.sv =====
`timescale 1ns / 1ps

module pwt_table_mem import pwt_pkg::*; #(
  parameter int TABLE_FRAMES = PWT_TABLE_FRAMES,
  localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/page_table_walker.sv =====
`timescale 1ns / 1ps
// channel  dir  fields (tdata/tuser low bit up)
// s_*      in   tdata: virt_address[56:0] phys_address[120:57] page_flags[132:121]
//               tuser: operation
// m_*      out  tdata: translated_address   tuser: status
// cfg_*    in   index 0 paging_mode, 1 table_base_address
//
// Accept, then a read and an evaluate state per walked level on the single-port
// table memory, then a finish state that loads the output register; map and
// unmap skip the leaf evaluate and a failed walk ends early. One request in
// flight at a time. After reset a clearing pass zeroes all TABLE_FRAMES*512
// entries with s_tready low. A stalled result holds in the output register; the
// next request is accepted meanwhile and waits at its end for the register.

module page_table_walker import pwt_pkg::*; #(
  parameter int TABLE_FRAMES = PWT_TABLE_FRAMES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // virt_address, phys_address, page_flags
  input  logic [1:0]           s_tuser,  // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // translated_address
  output logic [1:0]           m_tuser,  // status
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [TBA_W-1:0]     cfg_data
);

  localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FRAME_W = ADDR_W - IDX_W;
  localparam int NFF_W = $clog2(TABLE_FRAMES + 1);
  localparam int FSUM_W = TBA_W - PAGE_SHIFT + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic                paging_mode;
  logic [TBA_W-1:0]    table_base;
  logic [NFF_W-1:0]    next_free_frame;
  op_t                 op;
  logic [VA_W-1:0]     va;
  logic [PA_W-1:0]     pa;
  logic [FLAGS_W-1:0]  flags;
  logic [2:0]          lvl;
  logic [FRAME_W-1:0]  frame;
  status_t             res_status;
  logic [ENTRY_W-1:0]  res_addr;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ENTRY_W-1:0]  mem_rdata;

  logic [IDX_W-1:0]    idx;
  logic [ENTRY_W-1:0]  base64;
  logic [ENTRY_W-1:0]  next_addr;
  logic [ENTRY_W:0]    diff;
  logic                outside;
  logic                exhausted;
  logic [FSUM_W-1:0]   fsum;
  logic [ENTRY_W-1:0]  link;

  always_comb begin
    unique case (lvl)
      3'd5:    idx = va[48 +: IDX_W];
      3'd4:    idx = va[39 +: IDX_W];
      3'd3:    idx = va[30 +: IDX_W];
      3'd2:    idx = va[21 +: IDX_W];
      default: idx = va[12 +: IDX_W];
    endcase
  end

  assign base64    = {12'd0, table_base[TBA_W-1:PAGE_SHIFT], 12'd0};
  assign next_addr = {mem_rdata[ENTRY_W-1:PAGE_SHIFT], 12'd0};
  assign diff      = {1'b0, next_addr} - {1'b0, base64};
  assign outside   = diff[ENTRY_W] ||
                     (diff[ENTRY_W-1:PAGE_SHIFT] >= (ENTRY_W-PAGE_SHIFT)'(TABLE_FRAMES));
  assign exhausted = next_free_frame >= NFF_W'(TABLE_FRAMES);
  assign fsum      = FSUM_W'(table_base[TBA_W-1:PAGE_SHIFT]) + FSUM_W'(next_free_frame);
  assign link      = {(ENTRY_W-PAGE_SHIFT)'(fsum), 12'd0} | LINK_BITS;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {frame, idx};
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_READ: begin
        if (lvl == 3'd1 && op != OP_TRANSLATE) begin
          mem_we    = 1'b1;
          mem_wdata = (op == OP_MAP) ? {pa[PA_W-1:FLAGS_W], pa[FLAGS_W-1:0] | flags} : '0;
        end
      end
      S_EVAL: begin
        if (lvl != 3'd1 && !mem_rdata[0] && op == OP_MAP && !exhausted) begin
          mem_we    = 1'b1;
          mem_wdata = link;
        end
      end
      default: ;
    endcase
  end

  pwt_table_mem #(.TABLE_FRAMES(TABLE_FRAMES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      paging_mode     <= 1'b0;
      table_base      <= '0;
      next_free_frame <= NFF_W'(1);
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PAGING_MODE: paging_mode <= cfg_data[0];
          REG_TABLE_BASE:  table_base  <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= op_t'(s_tuser);
            va         <= s_tdata[VA_W-1:0];
            pa         <= s_tdata[VA_W +: PA_W];
            flags      <= s_tdata[VA_W+PA_W +: FLAGS_W];
            lvl        <= paging_mode ? 3'd5 : 3'd4;
            frame      <= '0;
            res_status <= ST_OK;
            res_addr   <= '0;
            state      <= (op_t'(s_tuser) == OP_NONE) ? S_FINISH : S_READ;
          end
        end
        S_READ: begin
          if (lvl == 3'd1 && op != OP_TRANSLATE) begin
            state <= S_FINISH;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (lvl == 3'd1) begin
            if (mem_rdata[0]) begin
              res_addr <= next_addr;
            end else begin
              res_status <= ST_UNMAPPED;
            end
            state <= S_FINISH;
          end else if (mem_rdata[0]) begin
            if (outside) begin
              res_status <= ST_OUTSIDE;
              state      <= S_FINISH;
            end else begin
              frame <= diff[PAGE_SHIFT +: FRAME_W];
              lvl   <= lvl - 3'd1;
              state <= S_READ;
            end
          end else if (op != OP_MAP) begin
            res_status <= ST_UNMAPPED;
            state      <= S_FINISH;
          end else if (exhausted) begin
            res_status <= ST_NOFRAME;
            state      <= S_FINISH;
          end else begin
            frame           <= next_free_frame[FRAME_W-1:0];
            next_free_frame <= next_free_frame + NFF_W'(1);
            lvl             <= lvl - 3'd1;
            state           <= S_READ;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_addr;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pwt_checker.sv =====
`timescale 1ns / 1ps

module pwt_checker import pwt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  // table memory is cleared before the first request
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request accepted during clearing pass");

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request accepted while walking");

  // address only on a successful translate, always page aligned
  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("address with error status");

  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:0] == 12'd0)
    else $error("translated address not page aligned");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind page_table_walker pwt_checker u_pwt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/tb_page_table_walker.sv =====
`timescale 1ns / 1ps

module tb_page_table_walker;
  import pwt_pkg::*;

  localparam int FRAMES      = PWT_TABLE_FRAMES;
  localparam int STORE_DEPTH = PWT_TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int IDLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES = 24;
  localparam int RAND_PER_PHASE = 80;
  localparam int PHASES = 5;

  class walk_scoreboard;
    bit [ENTRY_W-1:0] table_mem [STORE_DEPTH];
    int unsigned      alloc_frame;
    bit               five_level;
    bit [TBA_W-1:0]   base_reg;
    status_t          status_q [$];
    bit [PA_W-1:0]    addr_q [$];
    int               errors;
    int               accepted;
    int               status_seen [4];

    function new();
      alloc_frame = 1;
      five_level  = 1'b0;
      base_reg    = '0;
      errors      = 0;
      accepted    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_config(logic idx, bit [TBA_W-1:0] value);
      if (idx == REG_PAGING_MODE) five_level = value[0];
      else base_reg = value;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function status_t descend(bit [VA_W-1:0] va, bit alloc, output int unsigned leaf);
      bit [ENTRY_W-1:0] root_addr;
      bit [ENTRY_W-1:0] ent;
      bit [ENTRY_W-1:0] nxt;
      bit [ENTRY_W-1:0] off;
      bit [IDX_W-1:0]   idx;
      int unsigned      frame;
      int unsigned      s;
      leaf      = 0;
      frame     = 0;
      root_addr = {12'b0, base_reg} & ~64'hfff;
      for (int lvl = (five_level ? 5 : 4); lvl > 1; lvl--) begin
        idx = IDX_W'(va >> (PAGE_SHIFT + IDX_W * (lvl - 1)));
        s   = frame * ENTRIES_PER_TABLE + idx;
        ent = table_mem[s];
        if (ent[0]) begin
          nxt = ent & ~64'hfff;
        end else begin
          if (!alloc) return ST_UNMAPPED;
          if (alloc_frame >= FRAMES) return ST_NOFRAME;
          nxt = root_addr + (64'(alloc_frame) << PAGE_SHIFT);
          alloc_frame++;
          table_mem[s] = nxt | LINK_BITS;
        end
        if (nxt < root_addr) return ST_OUTSIDE;
        off = (nxt - root_addr) >> PAGE_SHIFT;
        if (off >= FRAMES) return ST_OUTSIDE;
        frame = int'(off);
      end
      leaf = frame * ENTRIES_PER_TABLE + va[20:12];
      return ST_OK;
    endfunction

    function void note_request(op_t op, bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                               bit [FLAGS_W-1:0] fl);
      status_t       st;
      bit [PA_W-1:0] addr;
      int unsigned   leaf;
      st   = ST_OK;
      addr = '0;
      accepted++;
      case (op)
        OP_TRANSLATE: begin
          st = descend(va, 1'b0, leaf);
          if (st == ST_OK) begin
            if (table_mem[leaf][0]) addr = table_mem[leaf] & ~64'hfff;
            else st = ST_UNMAPPED;
          end
        end
        OP_MAP: begin
          st = descend(va, 1'b1, leaf);
          if (st == ST_OK) table_mem[leaf] = pa | {52'b0, fl};
        end
        OP_UNMAP: begin
          st = descend(va, 1'b0, leaf);
          if (st == ST_OK) table_mem[leaf] = '0;
        end
        default: ;
      endcase
      status_q.push_back(st);
      addr_q.push_back(addr);
    endfunction

    function void check_result(logic [1:0] st, logic [PA_W-1:0] addr);
      status_t       exp_st;
      bit [PA_W-1:0] exp_addr;
      if (status_q.size() == 0) begin
        $error("result with no pending request: status %0d translated_address 0x%016h",
               st, addr);
        errors++;
        return;
      end
      exp_st   = status_q.pop_front();
      exp_addr = addr_q.pop_front();
      status_seen[exp_st]++;
      if (st !== exp_st) begin
        $error("status expected %0d actual %0d", exp_st, st);
        errors++;
      end
      if (addr !== exp_addr) begin
        $error("translated_address expected 0x%016h actual 0x%016h", exp_addr, addr);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = OP_TRANSLATE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = REG_PAGING_MODE;
  logic [TBA_W-1:0]     cfg_data = '0;

  page_table_walker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  walk_scoreboard sb = new();

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int             idle_cycles = 0;
  bit [TBA_W-1:0] cur_base = '0;
  bit [IDX_W-1:0] region_idx [2:5][2];
  bit [IDX_W-1:0] leaf_pick [8];

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(op_t op, bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                              bit [FLAGS_W-1:0] fl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {3'b0, fl, pa, va};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, va, pa, fl);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [TBA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_config(idx, value);
    if (idx == REG_TABLE_BASE) cur_base = value;
  endtask

  // fresh table path per phase; the second choice of the top slices reuses
  // the previous region so stale links are walked after a base change
  task automatic new_region();
    bit [IDX_W-1:0] prev;
    for (int lvl = 2; lvl <= 5; lvl++) begin
      prev = region_idx[lvl][0];
      region_idx[lvl][0] = IDX_W'($urandom_range(511));
      region_idx[lvl][1] = (lvl >= 4) ? prev : IDX_W'($urandom_range(511));
    end
    leaf_pick[0] = '0;
    leaf_pick[1] = '1;
    for (int i = 2; i < 8; i++) leaf_pick[i] = IDX_W'($urandom_range(511));
  endtask

  function automatic bit [VA_W-1:0] region_va();
    bit [VA_W-1:0] va;
    va[11:0] = 12'($urandom);
    va[20:12] = leaf_pick[$urandom_range(7)];
    for (int lvl = 2; lvl <= 5; lvl++)
      va[PAGE_SHIFT + IDX_W * (lvl - 1) +: IDX_W] =
        region_idx[lvl][($urandom_range(3) == 0) ? 1 : 0];
    return va;
  endfunction

  task automatic send_random(int unsigned noise_pct);
    int unsigned      r;
    op_t              op;
    bit [VA_W-1:0]    va;
    bit [PA_W-1:0]    pa;
    bit [FLAGS_W-1:0] fl;
    r = $urandom_range(99);
    if (r < 40) op = OP_MAP;
    else if (r < 75) op = OP_TRANSLATE;
    else if (r < 92) op = OP_UNMAP;
    else op = OP_NONE;
    if ($urandom_range(99) < noise_pct) va = VA_W'({$urandom, $urandom});
    else va = region_va();
    if ($urandom_range(3) == 0)
      pa = ({12'b0, cur_base} & ~64'hfff) + (64'($urandom_range(70)) << PAGE_SHIFT);
    else
      pa = {$urandom, $urandom};
    fl = FLAGS_W'($urandom_range(4095));
    if ($urandom_range(4) != 0) fl[0] = 1'b1;
    send_request(op, va, pa, fl);
  endtask

  initial begin
    bit [TBA_W-1:0] bases [PHASES];
    bit             modes [PHASES];
    bases = '{52'h0, 52'h0, 52'hf_ffff_ffff_ffff, TBA_W'({$urandom, $urandom}), 52'h0};
    modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    foreach (region_idx[l, c]) region_idx[l][c] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      write_reg(REG_PAGING_MODE, TBA_W'(modes[p]));
      write_reg(REG_TABLE_BASE, bases[p]);
      new_region();

      if (p == 0) begin
        send_request(OP_TRANSLATE, '0, '0, '0);
        send_request(OP_UNMAP, '0, '0, '0);
        send_request(OP_MAP, '0, '0, '0);
        send_request(OP_TRANSLATE, '0, '0, '0);
        send_request(OP_UNMAP, '0, '0, '0);
        send_request(OP_MAP, '0, '1, '1);
        send_request(OP_TRANSLATE, '0, '0, '0);
        send_request(OP_MAP, '1, 64'h1000, 12'h001);
        send_request(OP_TRANSLATE, '1, '0, '0);
        send_request(OP_NONE, '1, '1, '1);
        send_request(OP_UNMAP, '1, '1, '1);
        send_request(OP_TRANSLATE, '1, '0, '0);
        send_request(OP_MAP, 57'h20_0000, 64'h4_0000, 12'h007);
        send_request(OP_TRANSLATE, 57'h20_0fff, '0, '0);
        send_request(OP_MAP, 57'h1ff_0000_0000_0000, 64'h8000_0000_0000_0000, 12'hffe);
        send_request(OP_TRANSLATE, 57'h1ff_0000_0000_0000, '0, '0);
      end

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        send_random((p == PHASES - 1) ? 50 : 10);
        if (p == 1 && i == RAND_PER_PHASE / 2) drain_results();
      end
      drain_results();
    end

    $display("Covered %0d requests in %0d phases: both walk depths, table bases from zero to the top.",
             sb.accepted, PHASES);
    $display("Statuses seen: ok %0d, not mapped %0d, no free frame %0d, outside store %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_UNMAPPED],
             sb.status_seen[ST_NOFRAME], sb.status_seen[ST_OUTSIDE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
